FILE: design/mission_transfer_protocol_defines.svh
// Assertion helpers for the mission transfer block.
// Each macro needs clk_i and rst_ni in scope.
`ifndef MISSION_TRANSFER_PROTOCOL_DEFINES_SVH
`define MISSION_TRANSFER_PROTOCOL_DEFINES_SVH

// Same-cycle implication
`define MTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtp: implication check failed");

// Next-cycle implication
`define MTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtp: next-cycle check failed");

`endif

FILE: design/mtp_pkg.sv
`timescale 1ns / 1ps

package mtp_pkg;

  // Event kinds
  localparam logic [2:0] KIND_COUNT    = 3'd0;
  localparam logic [2:0] KIND_ITEM     = 3'd1;
  localparam logic [2:0] KIND_REQ_LIST = 3'd2;
  localparam logic [2:0] KIND_REQ_ITEM = 3'd3;
  localparam logic [2:0] KIND_ACK      = 3'd4;
  localparam logic [2:0] KIND_CLEAR    = 3'd5;
  localparam logic [2:0] KIND_TICK     = 3'd6;

  // Outgoing message kinds
  localparam logic [2:0] MSG_NONE  = 3'd0;
  localparam logic [2:0] MSG_COUNT = 3'd1;
  localparam logic [2:0] MSG_REQ   = 3'd2;
  localparam logic [2:0] MSG_ITEM  = 3'd3;
  localparam logic [2:0] MSG_ACK   = 3'd4;

  // Acknowledge codes
  localparam logic [1:0] ACK_ACCEPTED    = 2'd0;
  localparam logic [1:0] ACK_ERROR       = 2'd1;
  localparam logic [1:0] ACK_NO_SPACE    = 2'd2;
  localparam logic [1:0] ACK_INVALID_SEQ = 2'd3;

  // Store commands
  localparam logic [1:0] STORE_NONE  = 2'd0;
  localparam logic [1:0] STORE_CLEAR = 2'd1;
  localparam logic [1:0] STORE_ADD   = 2'd2;
  localparam logic [1:0] STORE_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_RETRIES   = 2'd1;
  localparam logic [1:0] CFG_WAYPOINTS = 2'd2;

  // Configuration reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
  localparam logic [3:0]  RETRIES_RST   = 4'd5;
  localparam logic [15:0] WAYPOINTS_RST = 16'd64;

  localparam logic [7:0] TYPE_ALL       = 8'd255;
  localparam logic [7:0] BCAST_SYSTEM   = 8'd255;
  localparam logic [7:0] BCAST_COMP     = 8'd0;
  localparam logic [3:0] RETRY_SAT      = 4'd15;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  max_retries;
    logic [15:0] max_waypoints;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] item_count;
    logic [15:0] seq;
    logic [7:0]  plan_type;
    logic        store_ok;
    logic [15:0] stored_count;
    logic [7:0]  peer_system;
    logic [7:0]  peer_component;
  } event_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [15:0] msg_seq;
    logic [1:0]  ack_code;
    logic [7:0]  msg_plan_type;
    logic [1:0]  store_op;
    logic [7:0]  dest_system;
    logic [7:0]  dest_component;
    logic        upload_active;
    logic        download_active;
  } result_t;

  typedef struct packed {
    logic        receiving;
    logic        sending;
    logic [15:0] expected_count;
    logic [15:0] next_index;
    logic [7:0]  session_type;
    logic [15:0] recv_idle;
    logic [15:0] send_idle;
    logic [3:0]  retry_count;
  } sess_t;

endpackage

FILE: design/mtp_cfg_regs.sv
`timescale 1ns / 1ps

module mtp_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  output mtp_pkg::cfg_t       cfg_o
);

  mtp_pkg::cfg_t cfg_q;
  mtp_pkg::cfg_t cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mtp_pkg::CFG_TIMEOUT:   cfg_d.timeout_ticks = cfg_wdata_i;
        mtp_pkg::CFG_RETRIES:   cfg_d.max_retries   = cfg_wdata_i[3:0];
        mtp_pkg::CFG_WAYPOINTS: cfg_d.max_waypoints = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= mtp_pkg::TIMEOUT_RST;
      cfg_q.max_retries   <= mtp_pkg::RETRIES_RST;
      cfg_q.max_waypoints <= mtp_pkg::WAYPOINTS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/mtp_engine.sv
`timescale 1ns / 1ps

module mtp_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  mtp_pkg::event_t   ev_i,
  input  mtp_pkg::cfg_t     cfg_i,
  output mtp_pkg::result_t  res_o
);

  mtp_pkg::sess_t   st_q;
  mtp_pkg::sess_t   st_d;
  mtp_pkg::result_t res;
  logic [15:0]      nidx;

  assign nidx = st_q.next_index + 16'd1;

  // Session update and outgoing message for the event in the input stage
  always_comb begin
    st_d = st_q;
    res  = '0;
    case (ev_i.kind)
      mtp_pkg::KIND_COUNT: begin
        if (ev_i.item_count != 16'd0) begin
          res.dest_system    = ev_i.peer_system;
          res.dest_component = ev_i.peer_component;
          res.msg_plan_type  = ev_i.plan_type;
          if (ev_i.item_count > cfg_i.max_waypoints) begin
            res.msg_kind = mtp_pkg::MSG_ACK;
            res.ack_code = mtp_pkg::ACK_NO_SPACE;
          end else begin
            st_d.expected_count = ev_i.item_count;
            st_d.session_type   = ev_i.plan_type;
            st_d.receiving      = 1'b1;
            st_d.next_index     = '0;
            st_d.recv_idle      = '0;
            st_d.retry_count    = '0;
            res.store_op        = mtp_pkg::STORE_CLEAR;
            res.msg_kind        = mtp_pkg::MSG_REQ;
          end
        end
      end
      mtp_pkg::KIND_ITEM: begin
        if (st_q.receiving) begin
          res.dest_system    = ev_i.peer_system;
          res.dest_component = ev_i.peer_component;
          res.msg_plan_type  = st_q.session_type;
          if (ev_i.seq != st_q.next_index) begin
            // wrong sequence: ask again for the expected index
            res.msg_kind     = mtp_pkg::MSG_REQ;
            res.msg_seq      = st_q.next_index;
            st_d.recv_idle   = '0;
            st_d.retry_count = '0;
          end else begin
            res.store_op = mtp_pkg::STORE_ADD;
            if (!ev_i.store_ok) begin
              st_d.receiving = 1'b0;
              res.msg_kind   = mtp_pkg::MSG_ACK;
              res.ack_code   = mtp_pkg::ACK_ERROR;
            end else if (nidx == st_q.expected_count) begin
              st_d.receiving      = 1'b0;
              st_d.expected_count = '0;
              st_d.next_index     = '0;
              res.msg_kind        = mtp_pkg::MSG_ACK;
              res.ack_code        = mtp_pkg::ACK_ACCEPTED;
            end else begin
              st_d.next_index  = nidx;
              st_d.recv_idle   = '0;
              st_d.retry_count = '0;
              res.msg_kind     = mtp_pkg::MSG_REQ;
              res.msg_seq      = nidx;
            end
          end
        end
      end
      mtp_pkg::KIND_REQ_LIST: begin
        res.msg_kind       = mtp_pkg::MSG_COUNT;
        res.msg_seq        = ev_i.stored_count;
        res.dest_system    = ev_i.peer_system;
        res.dest_component = ev_i.peer_component;
        if (ev_i.stored_count != 16'd0) begin
          st_d.sending   = 1'b1;
          st_d.send_idle = '0;
        end
      end
      mtp_pkg::KIND_REQ_ITEM: begin
        if (st_q.sending) begin
          res.store_op       = mtp_pkg::STORE_READ;
          res.dest_system    = ev_i.peer_system;
          res.dest_component = ev_i.peer_component;
          if (!ev_i.store_ok) begin
            st_d.sending = 1'b0;
            res.msg_kind = mtp_pkg::MSG_ACK;
            res.ack_code = mtp_pkg::ACK_INVALID_SEQ;
          end else begin
            res.msg_kind      = mtp_pkg::MSG_ITEM;
            res.msg_seq       = ev_i.seq;
            res.msg_plan_type = st_q.session_type;
            st_d.send_idle    = '0;
          end
        end
      end
      mtp_pkg::KIND_ACK: begin
        st_d.sending = 1'b0;
      end
      mtp_pkg::KIND_CLEAR: begin
        res.msg_kind       = mtp_pkg::MSG_ACK;
        res.msg_plan_type  = mtp_pkg::TYPE_ALL;
        res.dest_system    = ev_i.peer_system;
        res.dest_component = ev_i.peer_component;
        if (st_q.sending || st_q.receiving) begin
          res.ack_code = mtp_pkg::ACK_ERROR;
        end else begin
          res.store_op = mtp_pkg::STORE_CLEAR;
          res.ack_code = mtp_pkg::ACK_ACCEPTED;
        end
      end
      mtp_pkg::KIND_TICK: begin
        // download: close silently on expiry
        if (st_q.sending) begin
          if (st_q.send_idle >= cfg_i.timeout_ticks) begin
            st_d.sending = 1'b0;
          end else begin
            st_d.send_idle = st_q.send_idle + 16'd1;
          end
        end
        // upload: re-request with broadcast target, or give up
        if (st_q.receiving) begin
          if (st_q.recv_idle >= cfg_i.timeout_ticks) begin
            if (st_q.retry_count <= cfg_i.max_retries) begin
              res.msg_kind       = mtp_pkg::MSG_REQ;
              res.msg_seq        = st_q.next_index;
              res.msg_plan_type  = st_q.session_type;
              res.dest_system    = mtp_pkg::BCAST_SYSTEM;
              res.dest_component = mtp_pkg::BCAST_COMP;
              st_d.recv_idle     = '0;
              if (st_q.retry_count != mtp_pkg::RETRY_SAT) begin
                st_d.retry_count = st_q.retry_count + 4'd1;
              end
            end else begin
              st_d.receiving = 1'b0;
            end
          end else begin
            st_d.recv_idle = st_q.recv_idle + 16'd1;
          end
        end
      end
      default: begin
        st_d = st_q;
      end
    endcase
    res.upload_active   = st_d.receiving;
    res.download_active = st_d.sending;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign res_o = res;

endmodule

FILE: design/mission_transfer_protocol.sv
// Mission transfer handshake: one result per accepted request.
// The request is held in the input register, passes the session logic and is
// loaded into the result register when that is free, which frees the input side.
// Throughput: one request per cycle while out_stall_i is low.
// Reset (rst_ni low, async): sessions closed, counters zero, both stages empty,
// timeout 2000, retries 5, waypoint limit 64.
`timescale 1ns / 1ps
`include "mission_transfer_protocol_defines.svh"

module mission_transfer_protocol (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] item_count_i,
  input  logic [15:0] seq_i,
  input  logic [7:0]  plan_type_i,
  input  logic        store_ok_i,
  input  logic [15:0] stored_count_i,
  input  logic [7:0]  peer_system_i,
  input  logic [7:0]  peer_component_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  msg_kind_o,
  output logic [15:0] msg_seq_o,
  output logic [1:0]  ack_code_o,
  output logic [7:0]  msg_plan_type_o,
  output logic [1:0]  store_op_o,
  output logic [7:0]  dest_system_o,
  output logic [7:0]  dest_component_o,
  output logic        upload_active_o,
  output logic        download_active_o
);

  mtp_pkg::cfg_t    cfg;
  mtp_pkg::event_t  ev_q;
  mtp_pkg::result_t res;
  mtp_pkg::result_t res_q;
  logic             in_valid_q;
  logic             in_valid_d;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             accept;
  logic             adv;
  logic             out_coded;
  logic             out_is_ack;
  logic             out_is_none;
  logic             out_blank;

  mtp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage handshake: input stage moves when the result register is free
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q.kind           <= kind_i;
      ev_q.item_count     <= item_count_i;
      ev_q.seq            <= seq_i;
      ev_q.plan_type      <= plan_type_i;
      ev_q.store_ok       <= store_ok_i;
      ev_q.stored_count   <= stored_count_i;
      ev_q.peer_system    <= peer_system_i;
      ev_q.peer_component <= peer_component_i;
    end
  end

  mtp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ev_i   (ev_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign msg_kind_o        = res_q.msg_kind;
  assign msg_seq_o         = res_q.msg_seq;
  assign ack_code_o        = res_q.ack_code;
  assign msg_plan_type_o   = res_q.msg_plan_type;
  assign store_op_o        = res_q.store_op;
  assign dest_system_o     = res_q.dest_system;
  assign dest_component_o  = res_q.dest_component;
  assign upload_active_o   = res_q.upload_active;
  assign download_active_o = res_q.download_active;

  // Terms for the checks
  assign out_coded   = out_valid_o && (ack_code_o != mtp_pkg::ACK_ACCEPTED);
  assign out_is_ack  = (msg_kind_o == mtp_pkg::MSG_ACK);
  assign out_is_none = out_valid_o && (msg_kind_o == mtp_pkg::MSG_NONE);
  assign out_blank   = (dest_system_o == 8'd0) && (msg_seq_o == 16'd0);

  // Checks
  `MTP_ASSERT_NXT(a_adv_loads_result, adv, out_valid_o)
  `MTP_ASSERT_IMP(a_stall_only_when_full, in_stall_o, in_valid_q && out_valid_q)
  `MTP_ASSERT_IMP(a_ack_code_only_on_ack, out_coded, out_is_ack)
  `MTP_ASSERT_IMP(a_none_has_no_dest, out_is_none, out_blank)

endmodule
